// ===== hw/rtl/fl31_pkg.sv =====
// Shared constants, coefficient table and control types for the 31-tap low-pass FIR.
// No dependencies; compile first.
package fl31_pkg;

	// default configuration of the filter
	localparam int unsigned TAPS_DEF           = 31;
	localparam int unsigned SAMPLE_BITS_DEF    = 10;
	localparam int unsigned COEF_FRAC_BITS_DEF = 16;

	// result word layout
	localparam int unsigned OUT_INT_BITS  = 10;
	localparam int unsigned OUT_FRAC_BITS = 16;
	localparam int unsigned OUT_INT_MAX   = 1023;

	// coefficients in units of 1e-5, indexed by tap (tap 0 is the newest sample)
	localparam int unsigned KNOWN_COEFS = 31;
	localparam int unsigned COEF_SCALE  = 100000;
	localparam int unsigned COEF_E5 [KNOWN_COEFS] = '{
		66, 120, 230, 430, 740, 1180, 1750, 2450, 3260, 4120,
		4990, 5810, 6530, 7080, 7430, 7550, 7430, 7080, 6530, 5810,
		4990, 4120, 3260, 2460, 1760, 1180, 740, 430, 235, 124, 66
	};

	// Round one coefficient to unsigned Q0.frac_bits, halves up; taps past the
	// known set are zero. Evaluated at elaboration only.
	function automatic longint unsigned coef_q(input int unsigned tap,
	                                           input int unsigned frac_bits);
		longint unsigned k;
		if (tap >= KNOWN_COEFS) begin
			return 64'd0;
		end
		k = longint'(COEF_E5[tap]);
		return (k * (64'd1 << frac_bits) + COEF_SCALE / 2) / COEF_SCALE;
	endfunction

	// controller state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_FINISH
	} fl31_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic shift_in;  // take the new sample, clear the accumulator and tap counter
		logic mac_step;  // multiply the current tap and rotate the delay line
		logic load_out;  // capture the finished sum into the result register
	} fl31_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last_tap;  // tap counter points at the final tap
	} fl31_sts_t;

endpackage

// ===== hw/rtl/fl31_smp_if.sv =====
// Sample channel: valid/ready handshake carrying one converter sample per word.
// Depends on fl31_pkg.
interface fl31_smp_if #(
	parameter int unsigned SAMPLE_BITS = fl31_pkg::SAMPLE_BITS_DEF
);
	import fl31_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);

endinterface

// ===== hw/rtl/fl31_res_if.sv =====
// Result channel: valid/ready handshake carrying one filtered value per word.
// Depends on fl31_pkg.
interface fl31_res_if;
	import fl31_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OUT_INT_BITS-1:0]  filtered_int;
	logic [OUT_FRAC_BITS-1:0] filtered_frac;

	modport source (output valid, output filtered_int, output filtered_frac, input ready);
	modport sink   (input valid, input filtered_int, input filtered_frac, output ready);

endinterface

// ===== hw/rtl/fir_lowpass_31_tap.sv =====
// Top level of the 31-tap low-pass FIR: sample in, filtered value out.
// Depends on fl31_pkg, fl31_smp_if, fl31_res_if, fl31_ctrl and fl31_dp.
//
//   channel  modport  payload                                   word
//   smp      sink     sample [SAMPLE_BITS]                      one converter sample
//   res      source   filtered_int [10], filtered_frac [16]     one filtered value
//
// A sample is finished before the next one is accepted: one multiply-accumulate
// per tap on the single shared multiplier (RUN), a FLUSH state to drain the
// product register, and a FINISH state to load the result.
// The result valid flag is registered and set by that load.
// Reset clears the delay line at once; the block is ready as soon as reset is released.
// A result waits in the output register until taken; the next sum waits before
// loading while the previous one is still held.
module fir_lowpass_31_tap #(
	parameter int unsigned TAPS           = fl31_pkg::TAPS_DEF,
	parameter int unsigned SAMPLE_BITS    = fl31_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COEF_FRAC_BITS = fl31_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fl31_smp_if.sink   smp,
	fl31_res_if.source res
);
	import fl31_pkg::*;

	fl31_cmd_t cmd;
	fl31_sts_t sts;

	// sequencer
	fl31_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (smp.valid),
		.in_ready  (smp.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic
	fl31_dp #(
		.TAPS           (TAPS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.sample        (smp.sample),
		.filtered_int  (res.filtered_int),
		.filtered_frac (res.filtered_frac)
	);

endmodule

// ===== hw/rtl/fl31_ctrl.sv =====
// Sequencer for the FIR: walks shift-in, one MAC per tap, pipeline flush, result load.
// Depends on fl31_pkg; drives the fl31_dp commands and owns the result valid flag.
module fl31_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fl31_pkg::fl31_sts_t sts,
	output fl31_pkg::fl31_cmd_t cmd
);
	import fl31_pkg::*;

	fl31_state_t state_q;
	fl31_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	// result register can take a new word when empty or being drained now
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	// hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.shift_in = 1'b0;
		cmd.mac_step = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.shift_in = 1'b1;
					state_d      = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.mac_step = 1'b1;
				if (sts.last_tap) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// set on load, drop when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/fl31_dp.sv =====
// FIR datapath: rotating delay line, coefficient table, one multiplier, accumulator,
// saturation and result register. Depends on fl31_pkg; sequenced by fl31_ctrl.
module fl31_dp #(
	parameter int unsigned TAPS           = fl31_pkg::TAPS_DEF,
	parameter int unsigned SAMPLE_BITS    = fl31_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COEF_FRAC_BITS = fl31_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fl31_pkg::fl31_cmd_t                cmd,
	output fl31_pkg::fl31_sts_t                sts,
	input  logic [SAMPLE_BITS-1:0]             sample,
	output logic [fl31_pkg::OUT_INT_BITS-1:0]  filtered_int,
	output logic [fl31_pkg::OUT_FRAC_BITS-1:0] filtered_frac
);
	import fl31_pkg::*;

	localparam int unsigned IDX_W  = $clog2(TAPS);
	localparam int unsigned COEF_W = COEF_FRAC_BITS;
	localparam int unsigned PROD_W = SAMPLE_BITS + COEF_W;
	localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS + 1);
	localparam int unsigned IP_W   = ACC_W - COEF_FRAC_BITS;

	logic [SAMPLE_BITS-1:0]   dl_q [TAPS];
	logic [COEF_W-1:0]        coef_tab [TAPS];
	logic [IDX_W-1:0]         cnt_q;
	logic [PROD_W-1:0]        prod_s1;
	logic                     prod_vld_s1;
	logic [ACC_W-1:0]         acc_q;
	logic [IP_W-1:0]          ipart;
	logic [OUT_FRAC_BITS-1:0] frac_w;
	logic                     sat;

	// constant coefficient table
	for (genvar g = 0; g < TAPS; g++) begin : g_coef
		assign coef_tab[g] = COEF_W'(coef_q(int'(g), COEF_FRAC_BITS));
	end

	// shift a new sample in, or rotate one place so entry 0 walks through every tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				dl_q[i] <= '0;
			end
		end else if (cmd.shift_in) begin
			dl_q[0] <= sample;
			for (int i = 1; i < TAPS; i++) begin
				dl_q[i] <= dl_q[i-1];
			end
		end else if (cmd.mac_step) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				dl_q[i] <= dl_q[i+1];
			end
			dl_q[TAPS-1] <= dl_q[0];
		end
	end

	// tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.shift_in) begin
			cnt_q <= '0;
		end else if (cmd.mac_step) begin
			cnt_q <= sts.last_tap ? '0 : cnt_q + 1'b1;
		end
	end

	assign sts.last_tap = (cnt_q == IDX_W'(TAPS - 1));

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.mac_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_step) begin
			prod_s1 <= {{SAMPLE_BITS{1'b0}}, coef_tab[cnt_q]} * {{COEF_W{1'b0}}, dl_q[0]};
		end
	end

	// accumulate exact products
	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){1'b0}}, prod_s1};
		end
	end

	// split into integer part and 16-bit fraction
	assign ipart = acc_q[ACC_W-1:COEF_FRAC_BITS];
	assign sat   = (ipart > IP_W'(OUT_INT_MAX));

	if (COEF_FRAC_BITS >= OUT_FRAC_BITS) begin : g_frac_trunc
		assign frac_w = acc_q[COEF_FRAC_BITS-1 -: OUT_FRAC_BITS];
	end else begin : g_frac_pad
		assign frac_w = {acc_q[COEF_FRAC_BITS-1:0], {(OUT_FRAC_BITS - COEF_FRAC_BITS){1'b0}}};
	end

	// result register, saturated at the top of the integer range
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			filtered_int  <= sat ? OUT_INT_BITS'(OUT_INT_MAX) : ipart[OUT_INT_BITS-1:0];
			filtered_frac <= sat ? '1 : frac_w;
		end
	end

endmodule

// ===== hw/rtl/fl31_chk.sv =====
// Port-level checks for fir_lowpass_31_tap, attached by the bind at the end.
// Depends on fl31_pkg.
module fl31_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [fl31_pkg::OUT_INT_BITS-1:0]  filtered_int,
	input logic [fl31_pkg::OUT_FRAC_BITS-1:0] filtered_frac
);
	import fl31_pkg::*;

	// a result word stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before it was taken");

	// a stalled result word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(filtered_int) && $stable(filtered_frac))
		else $error("stalled result changed");

	// one sample at a time: ready drops right after a sample is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while the previous one is in work");

	// a new result cannot appear too soon after taking a sample
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too soon after a sample");

endmodule

bind fir_lowpass_31_tap fl31_chk u_fl31_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (smp.valid),
	.in_ready      (smp.ready),
	.out_valid     (res.valid),
	.out_ready     (res.ready),
	.filtered_int  (res.filtered_int),
	.filtered_frac (res.filtered_frac)
);

// ===== sim/tb_fir_lowpass_31_tap.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fir_lowpass_31_tap: random-gap sample driver,
// stalling result monitor and a bit-exact predictor of the 31-tap filter with Q0.16 coefficients.
// Depends on fl31_pkg, fl31_smp_if, fl31_res_if and the filter RTL.
module tb_fir_lowpass_31_tap;
	import fl31_pkg::*;

	localparam int unsigned N_TAPS     = TAPS_DEF;
	localparam int unsigned Q_BITS     = COEF_FRAC_BITS_DEF;
	localparam int unsigned IDLE_LIMIT = 3000;

	// low-pass coefficients in units of 1e-5, tap 0 is the newest sample
	localparam int unsigned LP_COEF_E5 [N_TAPS] = '{
		66, 120, 230, 430, 740, 1180, 1750, 2450, 3260, 4120,
		4990, 5810, 6530, 7080, 7430, 7550, 7430, 7080, 6530, 5810,
		4990, 4120, 3260, 2460, 1760, 1180, 740, 430, 235, 124, 66
	};

	typedef struct packed {
		logic [OUT_INT_BITS-1:0]  fint;
		logic [OUT_FRAC_BITS-1:0] ffrac;
	} fir_word_t;

	typedef struct {
		logic [SAMPLE_BITS_DEF-1:0] value;
		bit                         wait_drain;  // hold until all results are back
	} smp_word_t;

	logic clk;
	logic arst_n;

	fl31_smp_if smp_ch ();
	fl31_res_if res_ch ();

	fir_lowpass_31_tap dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_ch),
		.res    (res_ch)
	);

	smp_word_t                  pending_samples [$];
	fir_word_t                  expected_outputs [$];
	logic [SAMPLE_BITS_DEF-1:0] sample_hist [N_TAPS] = '{default: '0};
	int unsigned                sent_cnt = 0;
	int unsigned                rcvd_cnt = 0;
	int unsigned                fail_cnt = 0;
	int unsigned                idle_cycles = 0;

	// Shift a sample into the history and return the filter output it yields.
	function automatic fir_word_t lowpass_predict(input logic [SAMPLE_BITS_DEF-1:0] s);
		longint unsigned acc;
		fir_word_t       w;
		for (int i = N_TAPS - 1; i > 0; i--) begin
			sample_hist[i] = sample_hist[i-1];
		end
		sample_hist[0] = s;
		acc = 0;
		for (int i = 0; i < N_TAPS; i++) begin
			acc += ((64'(LP_COEF_E5[i]) << Q_BITS) + COEF_SCALE / 2) / COEF_SCALE
			       * 64'(sample_hist[i]);
		end
		if ((acc >> Q_BITS) > OUT_INT_MAX) begin
			w.fint  = OUT_INT_BITS'(OUT_INT_MAX);
			w.ffrac = '1;
		end else begin
			w.fint  = acc[Q_BITS +: OUT_INT_BITS];
			w.ffrac = acc[Q_BITS-1:0];
		end
		return w;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return $urandom_range(0, 2);
		end else if (r < 92) begin
			return $urandom_range(3, 12);
		end
		return $urandom_range(20, 70);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
	                               input int unsigned got);
		$display("%0t ns: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
		fail_cnt++;
	endtask

	task automatic add_word(input int unsigned value, input bit drain);
		smp_word_t w;
		w.value      = SAMPLE_BITS_DEF'(value);
		w.wait_drain = drain;
		pending_samples.push_back(w);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Drive samples from the pending queue with random gaps between words.
	always @(posedge clk or negedge arst_n) begin : sample_driver
		int unsigned gap_left;
		int unsigned mode_cnt;
		bit          calm;
		bit          took;
		if (!arst_n) begin
			smp_ch.valid  <= 1'b0;
			smp_ch.sample <= '0;
			gap_left = 0;
			mode_cnt = 0;
			calm     = 1'b0;
		end else begin
			took = smp_ch.valid && smp_ch.ready;
			if (took) begin
				expected_outputs.push_back(lowpass_predict(smp_ch.sample));
				sent_cnt <= sent_cnt + 1;
				void'(pending_samples.pop_front());
				// switch between gap-free stretches and gappy ones now and then
				mode_cnt++;
				if (mode_cnt % 64 == 0) begin
					calm = ($urandom_range(0, 3) == 0);
				end
				gap_left = calm ? 0 : pick_gap();
			end
			if (!(smp_ch.valid && !smp_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					smp_ch.valid <= 1'b0;
				end else if (pending_samples.size() > 0 &&
				             (!pending_samples[0].wait_drain ||
				              (!took && sent_cnt == rcvd_cnt))) begin
					smp_ch.valid  <= 1'b1;
					smp_ch.sample <= pending_samples[0].value;
				end else begin
					smp_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Take results with random stalls and check them against the predictor.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int unsigned stall_left;
		int unsigned mode_cnt;
		bit          calm;
		fir_word_t   want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
			mode_cnt   = 0;
			calm       = 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				rcvd_cnt <= rcvd_cnt + 1;
				if (rcvd_cnt >= sent_cnt) begin
					report_mismatch("unexpected word", 0, 1);
				end else begin
					want = expected_outputs.pop_front();
					if (res_ch.filtered_int !== want.fint) begin
						report_mismatch("filtered_int", want.fint, res_ch.filtered_int);
					end
					if (res_ch.filtered_frac !== want.ffrac) begin
						report_mismatch("filtered_frac", want.ffrac, res_ch.filtered_frac);
					end
				end
				mode_cnt++;
				if (mode_cnt % 64 == 0) begin
					calm = ($urandom_range(0, 3) == 0);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = pick_gap();
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// End the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned total;
		int unsigned len;
		int unsigned seg;
		bit          drain;
		arst_n = 1'b0;

		// directed: extremes, single bits, an impulse and a full-scale step
		add_word(0, 1'b0);
		add_word(OUT_INT_MAX, 1'b0);
		add_word(1, 1'b0);
		add_word(10'h200, 1'b0);
		add_word(10'h2AA, 1'b0);
		add_word(10'h155, 1'b0);
		add_word(0, 1'b0);
		add_word(OUT_INT_MAX, 1'b1);
		for (int i = 0; i < 17; i++) begin
			add_word(OUT_INT_MAX, 1'b0);
		end

		// random segments: noise, long full-scale and zero runs, bit walks, full-scale toggles, near-extreme values
		while (pending_samples.size() < 25 + 1050) begin
			seg   = $urandom_range(0, 9);
			drain = ($urandom_range(0, 11) == 0);
			case (seg)
				0, 1, 2, 3: begin
					len = $urandom_range(4, 40);
					for (int i = 0; i < len; i++) begin
						add_word($urandom_range(0, 1023), drain && i == 0);
					end
				end
				4, 5: begin
					len = $urandom_range(31, 40);
					for (int i = 0; i < len; i++) begin
						add_word(OUT_INT_MAX, drain && i == 0);
					end
				end
				6: begin
					len = $urandom_range(31, 40);
					for (int i = 0; i < len; i++) begin
						add_word(0, drain && i == 0);
					end
				end
				7: begin
					for (int b = 0; b < SAMPLE_BITS_DEF; b++) begin
						add_word(1 << b, drain && b == 0);
					end
				end
				8: begin
					len = $urandom_range(10, 30);
					for (int i = 0; i < len; i++) begin
						add_word((i % 2) ? OUT_INT_MAX : 0, drain && i == 0);
					end
				end
				default: begin
					len = $urandom_range(5, 20);
					for (int i = 0; i < len; i++) begin
						add_word($urandom_range(0, 1) ? $urandom_range(1022, 1023)
						                              : $urandom_range(0, 1),
						         drain && i == 0);
					end
				end
			endcase
		end
		total = pending_samples.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every sample to go in and every result to come out
		do begin
			@(posedge clk);
		end while (sent_cnt != total || rcvd_cnt != total);
		repeat (N_TAPS + 8) @(posedge clk);

		if (expected_outputs.size() != 0) begin
			report_mismatch("missing words", 0, expected_outputs.size());
		end
		if (fail_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
